### rtl/core/scfd_pkg.sv
// Shared types, constants and rounding helpers for the stereo cross feedback delay.
// No dependencies; imported by scfd_mac, stereo_cross_feedback_delay and the testbench.
`default_nettype none

package scfd_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int FRAC_BITS     = 15;
  localparam int GAIN_BITS     = 15;
  localparam int ECHO_LEN_BITS = 15;
  localparam int ROOM_LEN_BITS = 14;
  localparam int PROD_BITS     = SAMPLE_BITS + GAIN_BITS + 1;
  // dry term plus two products, Q2.30 with headroom
  localparam int ACC_BITS      = PROD_BITS + 2;
  localparam int SHIFT_BITS    = ACC_BITS - FRAC_BITS;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 15;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_ECHO_LENGTH       = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROOM_LENGTH_LEFT  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROOM_LENGTH_RIGHT = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ECHO_FEEDBACK     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROOM_FEEDBACK     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ECHO_WET          = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROOM_WET          = 3'd6;

  localparam logic [ECHO_LEN_BITS-1:0] RST_ECHO_LENGTH       = 15'd15964;
  localparam logic [ROOM_LEN_BITS-1:0] RST_ROOM_LENGTH_LEFT  = 14'd7168;
  localparam logic [ROOM_LEN_BITS-1:0] RST_ROOM_LENGTH_RIGHT = 14'd9161;
  localparam logic [GAIN_BITS-1:0]     RST_ECHO_FEEDBACK     = 15'd11023;
  localparam logic [GAIN_BITS-1:0]     RST_ROOM_FEEDBACK     = 15'd17223;
  localparam logic [GAIN_BITS-1:0]     RST_ECHO_WET          = 15'd3617;
  localparam logic [GAIN_BITS-1:0]     RST_ROOM_WET          = 15'd4522;

  // 0.72 in Q0.15
  localparam logic [GAIN_BITS-1:0] DRY_ROOM_GAIN = 15'd23593;

  // output buffer slots
  localparam int OUT_DEPTH    = 2;
  localparam int OUT_PTR_BITS = 1;
  localparam int OUT_CNT_BITS = 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic        [GAIN_BITS-1:0]   gain_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;

  typedef struct packed {
    sample_t echo_l;
    sample_t echo_r;
    sample_t room_l;
    sample_t room_r;
  } tap_set_t;

  typedef struct packed {
    gain_t echo_fb;
    gain_t room_fb;
    gain_t echo_wet;
    gain_t room_wet;
  } gain_set_t;

  typedef struct packed {
    sample_t echo_l;
    sample_t echo_r;
    sample_t room_l;
    sample_t room_r;
    sample_t wet_l;
    sample_t wet_r;
  } result_set_t;

  function automatic prod_t mul_gain(input sample_t s, input gain_t g);
    logic signed [GAIN_BITS:0] g_s;
    g_s = {1'b0, g};
    return s * g_s;
  endfunction

  function automatic acc_t widen(input prod_t p);
    return {{(ACC_BITS-PROD_BITS){p[PROD_BITS-1]}}, p};
  endfunction

  // dry sample at unity gain, aligned to Q2.30
  function automatic acc_t dry_term(input sample_t s);
    return {{(ACC_BITS-SAMPLE_BITS-FRAC_BITS){s[SAMPLE_BITS-1]}}, s, {FRAC_BITS{1'b0}}};
  endfunction

  // round half up, floor shift to Q1.15, then clip to the sample range
  function automatic sample_t round_sat(input acc_t acc);
    localparam acc_t HALF = acc_t'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SHIFT_BITS-1:0] HI = SHIFT_BITS'((1 <<< (SAMPLE_BITS-1)) - 1);
    localparam logic signed [SHIFT_BITS-1:0] LO = SHIFT_BITS'(-(1 <<< (SAMPLE_BITS-1)));
    acc_t biased;
    logic signed [SHIFT_BITS-1:0] shifted;
    biased  = acc + HALF;
    shifted = biased[ACC_BITS-1:FRAC_BITS];
    if (shifted > HI) begin
      return sample_t'(HI);
    end else if (shifted < LO) begin
      return sample_t'(LO);
    end
    return shifted[SAMPLE_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/scfd_mac.sv
// Multiply and mix stages: registered gain products, then sum, round and clip.
// Depends on scfd_pkg.
`default_nettype none

module scfd_mac (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_v,
  input  scfd_pkg::sample_t     dry_left,
  input  scfd_pkg::sample_t     dry_right,
  input  scfd_pkg::tap_set_t    taps,
  input  scfd_pkg::gain_set_t   gains,
  output logic                  res_v,
  output scfd_pkg::result_set_t res
);
  import scfd_pkg::*;

  logic    v_r;
  sample_t dry_l_r, dry_r_r;
  prod_t   p_dl_room_r, p_dr_room_r;
  prod_t   p_el_fb_r, p_er_fb_r, p_rl_fb_r, p_rr_fb_r;
  prod_t   p_el_wet_r, p_er_wet_r, p_rl_wet_r, p_rr_wet_r;
  acc_t    dl, dr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (in_v) begin
      dry_l_r     <= dry_left;
      dry_r_r     <= dry_right;
      p_dl_room_r <= mul_gain(dry_left, DRY_ROOM_GAIN);
      p_dr_room_r <= mul_gain(dry_right, DRY_ROOM_GAIN);
      p_el_fb_r   <= mul_gain(taps.echo_l, gains.echo_fb);
      p_er_fb_r   <= mul_gain(taps.echo_r, gains.echo_fb);
      p_rl_fb_r   <= mul_gain(taps.room_l, gains.room_fb);
      p_rr_fb_r   <= mul_gain(taps.room_r, gains.room_fb);
      p_el_wet_r  <= mul_gain(taps.echo_l, gains.echo_wet);
      p_er_wet_r  <= mul_gain(taps.echo_r, gains.echo_wet);
      p_rl_wet_r  <= mul_gain(taps.room_l, gains.room_wet);
      p_rr_wet_r  <= mul_gain(taps.room_r, gains.room_wet);
    end
  end

  assign dl = dry_term(dry_l_r);
  assign dr = dry_term(dry_r_r);

  // echo lines and room lines feed each other crosswise
  always_comb begin
    res.echo_l = round_sat(dl + widen(p_er_fb_r));
    res.echo_r = round_sat(dr + widen(p_el_fb_r));
    res.room_l = round_sat(widen(p_dl_room_r) + widen(p_rr_fb_r));
    res.room_r = round_sat(widen(p_dr_room_r) + widen(p_rl_fb_r));
    res.wet_l  = round_sat(dl + widen(p_el_wet_r) + widen(p_rl_wet_r));
    res.wet_r  = round_sat(dr + widen(p_er_wet_r) + widen(p_rr_wet_r));
  end

  assign res_v = v_r;

endmodule

`default_nettype wire

### rtl/core/stereo_cross_feedback_delay.sv
// Stereo ping-pong echo with a cross-coupled room comb pair; top level.
// Depends on scfd_pkg and scfd_mac.
//
// Input channel in_valid/in_stall carries one stereo sample pair per
// transaction; the output channel out_valid/out_stall returns one processed
// pair per input, in order. The cfg_ channel writes one gain or length
// register per transaction (cfg_ready is always high); write only while idle.
// Each accepted pair is registered into stage 1 with its tap reads, then into the
// scfd_mac product registers and the output buffer before it shows on out_. A new
// pair is held off while one is in stage 1, set by the read, multiply and write-back
// of the delay memories; the last write-back is forwarded to the next pair's taps.
// A two-entry output buffer lets a new pair in while a result waits; with
// the buffer full and out_stall high, in_stall rises and the pipeline drains.
// Reset restores the register defaults and zeroes the write pointers. Delay
// memory entries not yet written since reset read as zero, tracked by the
// write pointer and a wrap flag, so no clearing pass is needed.
`default_nettype none

module stereo_cross_feedback_delay #(
  parameter int ECHO_DEPTH = 32768,
  parameter int ROOM_DEPTH = 16384
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  scfd_pkg::sample_t                      in_dry_left,
  input  scfd_pkg::sample_t                      in_dry_right,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output scfd_pkg::sample_t                      out_wet_left,
  output scfd_pkg::sample_t                      out_wet_right,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [scfd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [scfd_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import scfd_pkg::*;

  localparam int EAW = $clog2(ECHO_DEPTH);
  localparam int RAW = $clog2(ROOM_DEPTH);
  localparam int ELW = (EAW > ECHO_LEN_BITS) ? EAW : ECHO_LEN_BITS;
  localparam int RLW = (RAW > ROOM_LEN_BITS) ? RAW : ROOM_LEN_BITS;
  localparam int WORD_BITS = 2 * SAMPLE_BITS;

  // ---------------- configuration ----------------
  logic [ECHO_LEN_BITS-1:0] echo_len_r;
  logic [ROOM_LEN_BITS-1:0] room_len_l_r, room_len_r_r;
  gain_set_t                gains_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_len_r       <= RST_ECHO_LENGTH;
      room_len_l_r     <= RST_ROOM_LENGTH_LEFT;
      room_len_r_r     <= RST_ROOM_LENGTH_RIGHT;
      gains_r.echo_fb  <= RST_ECHO_FEEDBACK;
      gains_r.room_fb  <= RST_ROOM_FEEDBACK;
      gains_r.echo_wet <= RST_ECHO_WET;
      gains_r.room_wet <= RST_ROOM_WET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ECHO_LENGTH:       echo_len_r       <= cfg_data[ECHO_LEN_BITS-1:0];
        CFG_ROOM_LENGTH_LEFT:  room_len_l_r     <= cfg_data[ROOM_LEN_BITS-1:0];
        CFG_ROOM_LENGTH_RIGHT: room_len_r_r     <= cfg_data[ROOM_LEN_BITS-1:0];
        CFG_ECHO_FEEDBACK:     gains_r.echo_fb  <= cfg_data[GAIN_BITS-1:0];
        CFG_ROOM_FEEDBACK:     gains_r.room_fb  <= cfg_data[GAIN_BITS-1:0];
        CFG_ECHO_WET:          gains_r.echo_wet <= cfg_data[GAIN_BITS-1:0];
        CFG_ROOM_WET:          gains_r.room_wet <= cfg_data[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- tap addressing ----------------
  // length is clipped to [1, depth-1], tap sits that far behind the write pointer
  function automatic logic [EAW-1:0] echo_tap_addr(input logic [ECHO_LEN_BITS-1:0] len,
                                                   input logic [EAW-1:0] wp);
    logic [ELW-1:0] len_x;
    logic [EAW-1:0] len_c;
    logic [EAW:0]   diff;
    len_x = ELW'(len);
    if (len_x == '0) begin
      len_c = EAW'(1);
    end else if (len_x > ELW'(ECHO_DEPTH - 1)) begin
      len_c = EAW'(ECHO_DEPTH - 1);
    end else begin
      len_c = len_x[EAW-1:0];
    end
    diff = {1'b0, wp} - {1'b0, len_c};
    if (diff[EAW]) begin
      diff = diff + (EAW+1)'(ECHO_DEPTH);
    end
    return diff[EAW-1:0];
  endfunction

  function automatic logic [RAW-1:0] room_tap_addr(input logic [ROOM_LEN_BITS-1:0] len,
                                                   input logic [RAW-1:0] wp);
    logic [RLW-1:0] len_x;
    logic [RAW-1:0] len_c;
    logic [RAW:0]   diff;
    len_x = RLW'(len);
    if (len_x == '0) begin
      len_c = RAW'(1);
    end else if (len_x > RLW'(ROOM_DEPTH - 1)) begin
      len_c = RAW'(ROOM_DEPTH - 1);
    end else begin
      len_c = len_x[RAW-1:0];
    end
    diff = {1'b0, wp} - {1'b0, len_c};
    if (diff[RAW]) begin
      diff = diff + (RAW+1)'(ROOM_DEPTH);
    end
    return diff[RAW-1:0];
  endfunction

  logic           in_accept;
  logic [EAW-1:0] ewp_r, ewp_nxt, e_raddr;
  logic [RAW-1:0] rwp_r, rwp_nxt, rl_raddr, rr_raddr;
  logic           e_wrap_r, r_wrap_r;

  assign in_accept = in_valid && !in_stall;
  assign e_raddr   = echo_tap_addr(echo_len_r, ewp_r);
  assign rl_raddr  = room_tap_addr(room_len_l_r, rwp_r);
  assign rr_raddr  = room_tap_addr(room_len_r_r, rwp_r);
  assign ewp_nxt   = (ewp_r == EAW'(ECHO_DEPTH - 1)) ? '0 : ewp_r + 1'b1;
  assign rwp_nxt   = (rwp_r == RAW'(ROOM_DEPTH - 1)) ? '0 : rwp_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ewp_r    <= '0;
      rwp_r    <= '0;
      e_wrap_r <= 1'b0;
      r_wrap_r <= 1'b0;
    end else if (in_accept) begin
      ewp_r <= ewp_nxt;
      rwp_r <= rwp_nxt;
      if (ewp_nxt == '0) begin
        e_wrap_r <= 1'b1;
      end
      if (rwp_nxt == '0) begin
        r_wrap_r <= 1'b1;
      end
    end
  end

  // ---------------- stage 1: memory read ----------------
  logic           s1_v_r;
  sample_t        s1_dry_l_r, s1_dry_r_r;
  logic [EAW-1:0] s1_er_r, s1_ewp_r;
  logic [RAW-1:0] s1_rrl_r, s1_rrr_r, s1_rwp_r;
  logic           s1_e_seen_r, s1_rl_seen_r, s1_rr_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_dry_l_r   <= in_dry_left;
      s1_dry_r_r   <= in_dry_right;
      s1_er_r      <= e_raddr;
      s1_rrl_r     <= rl_raddr;
      s1_rrr_r     <= rr_raddr;
      s1_ewp_r     <= ewp_r;
      s1_rwp_r     <= rwp_r;
      // entries behind the write pointer, or all after a wrap, hold written data
      s1_e_seen_r  <= e_wrap_r || (e_raddr < ewp_r);
      s1_rl_seen_r <= r_wrap_r || (rl_raddr < rwp_r);
      s1_rr_seen_r <= r_wrap_r || (rr_raddr < rwp_r);
    end
  end

  // word layout: right sample high, left sample low
  logic [WORD_BITS-1:0]   echo_mem [ECHO_DEPTH];
  logic [WORD_BITS-1:0]   room_mem [ROOM_DEPTH];
  logic [WORD_BITS-1:0]   echo_q_r;
  logic [SAMPLE_BITS-1:0] room_l_q_r, room_r_q_r;

  logic                 mem_we;
  logic [EAW-1:0]       s2_ewp_r;
  logic [RAW-1:0]       s2_rwp_r;
  logic [WORD_BITS-1:0] echo_wdata, room_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      echo_mem[s2_ewp_r] <= echo_wdata;
    end
    echo_q_r <= echo_mem[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      room_mem[s2_rwp_r] <= room_wdata;
    end
    room_l_q_r <= room_mem[rl_raddr][SAMPLE_BITS-1:0];
    room_r_q_r <= room_mem[rr_raddr][WORD_BITS-1:SAMPLE_BITS];
  end

  // last write-back, forwarded when the next transaction taps the same entry
  logic                 wb_v_r;
  logic [EAW-1:0]       wb_ewp_r;
  logic [RAW-1:0]       wb_rwp_r;
  logic [WORD_BITS-1:0] wb_echo_r, wb_room_r;
  logic                 e_hit, rl_hit, rr_hit;
  tap_set_t             taps;

  assign e_hit  = wb_v_r && (s1_er_r == wb_ewp_r);
  assign rl_hit = wb_v_r && (s1_rrl_r == wb_rwp_r);
  assign rr_hit = wb_v_r && (s1_rrr_r == wb_rwp_r);

  always_comb begin
    taps.echo_l = '0;
    taps.echo_r = '0;
    taps.room_l = '0;
    taps.room_r = '0;
    if (e_hit) begin
      taps.echo_l = wb_echo_r[SAMPLE_BITS-1:0];
      taps.echo_r = wb_echo_r[WORD_BITS-1:SAMPLE_BITS];
    end else if (s1_e_seen_r) begin
      taps.echo_l = echo_q_r[SAMPLE_BITS-1:0];
      taps.echo_r = echo_q_r[WORD_BITS-1:SAMPLE_BITS];
    end
    if (rl_hit) begin
      taps.room_l = wb_room_r[SAMPLE_BITS-1:0];
    end else if (s1_rl_seen_r) begin
      taps.room_l = room_l_q_r;
    end
    if (rr_hit) begin
      taps.room_r = wb_room_r[WORD_BITS-1:SAMPLE_BITS];
    end else if (s1_rr_seen_r) begin
      taps.room_r = room_r_q_r;
    end
  end

  // ---------------- stages 2 and 3: multiply, mix ----------------
  logic        res_v;
  result_set_t res;

  scfd_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_v      (s1_v_r),
    .dry_left  (s1_dry_l_r),
    .dry_right (s1_dry_r_r),
    .taps      (taps),
    .gains     (gains_r),
    .res_v     (res_v),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_ewp_r <= s1_ewp_r;
      s2_rwp_r <= s1_rwp_r;
    end
  end

  assign mem_we     = res_v;
  assign echo_wdata = {res.echo_r, res.echo_l};
  assign room_wdata = {res.room_r, res.room_l};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_v_r <= 1'b0;
    end else if (res_v) begin
      wb_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_v) begin
      wb_ewp_r  <= s2_ewp_r;
      wb_rwp_r  <= s2_rwp_r;
      wb_echo_r <= echo_wdata;
      wb_room_r <= room_wdata;
    end
  end

  // ---------------- output buffer ----------------
  sample_t                 obuf_l_r [OUT_DEPTH];
  sample_t                 obuf_r_r [OUT_DEPTH];
  logic [OUT_PTR_BITS-1:0] obuf_wp_r, obuf_rp_r;
  logic [OUT_CNT_BITS-1:0] obuf_cnt_r, obuf_cnt_nxt;
  logic                    out_pop;

  assign out_pop = out_valid && !out_stall;

  always_comb begin
    obuf_cnt_nxt = obuf_cnt_r;
    if (res_v && !out_pop) begin
      obuf_cnt_nxt = obuf_cnt_r + 1'b1;
    end else if (!res_v && out_pop) begin
      obuf_cnt_nxt = obuf_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obuf_wp_r  <= '0;
      obuf_rp_r  <= '0;
      obuf_cnt_r <= '0;
    end else begin
      obuf_cnt_r <= obuf_cnt_nxt;
      if (res_v) begin
        obuf_wp_r <= obuf_wp_r + 1'b1;
      end
      if (out_pop) begin
        obuf_rp_r <= obuf_rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_v) begin
      obuf_l_r[obuf_wp_r] <= res.wet_l;
      obuf_r_r[obuf_wp_r] <= res.wet_r;
    end
  end

  assign out_valid     = (obuf_cnt_r != '0);
  assign out_wet_left  = obuf_l_r[obuf_rp_r];
  assign out_wet_right = obuf_r_r[obuf_rp_r];

  // room for this transaction's result is reserved at accept
  assign in_stall = s1_v_r || ((obuf_cnt_r + {1'b0, res_v}) >= OUT_CNT_BITS'(OUT_DEPTH));

endmodule

`default_nettype wire

### rtl/core/scfd_check.sv
// Port-level assertions for stereo_cross_feedback_delay, with the bind that attaches them.
// Depends on scfd_pkg.
`default_nettype none

module scfd_check (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input scfd_pkg::sample_t out_wet_left,
  input scfd_pkg::sample_t out_wet_right
);

  a_out_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_hold_data : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_wet_left) && $stable(out_wet_right))
    else $error("output sample changed while stalled");

  // no two transactions are accepted back to back
  a_accept_spacing : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on consecutive cycles");

  // an empty output side only fills from an earlier accepted input transaction
  a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 3))
    else $error("result appeared without a matching input transaction");

endmodule

bind stereo_cross_feedback_delay scfd_check u_scfd_check (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_wet_left  (out_wet_left),
  .out_wet_right (out_wet_right)
);

`default_nettype wire

### tb/stereo_cross_feedback_delay_tb.sv
// Self-checking testbench for stereo_cross_feedback_delay: a directed table, then random
// stereo pairs over several register settings, checked against a behavioral echo/room model.
// Depends on scfd_pkg and the stereo_cross_feedback_delay RTL.
`timescale 1ns / 1ps

module stereo_cross_feedback_delay_tb;
  import scfd_pkg::*;

  localparam int ECHO_DEPTH      = 32768;
  localparam int ROOM_DEPTH      = 16384;
  localparam int RAND_PHASES     = 7;
  localparam int PAIRS_PER_PHASE = 186;
  localparam int HOLD_CYCLES     = 400;
  localparam int RUN_LIMIT       = 500000;
  localparam int PROBE_ROWS      = 20;
  localparam int PROBE_AT_RESET  = 10;
  localparam int PRINT_CAP       = 40;
  // index past the register list, must be ignored
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_INDEX = 3'd7;

  typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY} rx_mode_t;

  typedef struct packed {
    sample_t wl;
    sample_t wr;
  } wet_pair_t;

  typedef struct packed {
    logic [CFG_DATA_BITS-1:0] echo_len;
    logic [CFG_DATA_BITS-1:0] room_len_l;
    logic [CFG_DATA_BITS-1:0] room_len_r;
    logic [CFG_DATA_BITS-1:0] echo_fb;
    logic [CFG_DATA_BITS-1:0] room_fb;
    logic [CFG_DATA_BITS-1:0] echo_wet;
    logic [CFG_DATA_BITS-1:0] room_wet;
  } knob_set_t;

  typedef struct packed {
    sample_t dl;
    sample_t dr;
    logic    typed;
    sample_t wl;
    sample_t wr;
  } probe_row_t;

  // First rows run on reset settings with empty lines: the output is the dry pair.
  // The rest run with unit lengths and full gains, driving the feedback into clipping.
  probe_row_t probe_rows [PROBE_ROWS] = '{
    '{16'sh0000, 16'sh0000, 1'b1, 16'sh0000, 16'sh0000},
    '{16'sh7FFF, 16'sh8000, 1'b1, 16'sh7FFF, 16'sh8000},
    '{16'sh8000, 16'sh7FFF, 1'b1, 16'sh8000, 16'sh7FFF},
    '{16'shFFFF, 16'sh0001, 1'b1, 16'shFFFF, 16'sh0001},
    '{16'sh0001, 16'shFFFF, 1'b1, 16'sh0001, 16'shFFFF},
    '{16'sh7FFF, 16'sh7FFF, 1'b1, 16'sh7FFF, 16'sh7FFF},
    '{16'sh8000, 16'sh8000, 1'b1, 16'sh8000, 16'sh8000},
    '{16'sh5555, 16'shAAAA, 1'b1, 16'sh5555, 16'shAAAA},
    '{16'shAAAA, 16'sh5555, 1'b1, 16'shAAAA, 16'sh5555},
    '{16'sh0064, 16'sh0064, 1'b1, 16'sh0064, 16'sh0064},
    '{16'sh7FFF, 16'sh7FFF, 1'b0, 16'sh0000, 16'sh0000},
    '{16'sh7FFF, 16'sh8000, 1'b0, 16'sh0000, 16'sh0000},
    '{16'sh7FFF, 16'sh7FFF, 1'b0, 16'sh0000, 16'sh0000},
    '{16'sh8000, 16'sh8000, 1'b0, 16'sh0000, 16'sh0000},
    '{16'sh8000, 16'sh7FFF, 1'b0, 16'sh0000, 16'sh0000},
    '{16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
    '{16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
    '{16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
    '{16'sh4000, 16'shC000, 1'b0, 16'sh0000, 16'sh0000},
    '{16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000}
  };

  logic                      clk          = 1'b0;
  logic                      rst_n        = 1'b0;
  logic                      in_valid     = 1'b0;
  logic                      in_stall;
  sample_t                   in_dry_left  = '0;
  sample_t                   in_dry_right = '0;
  logic                      out_valid;
  logic                      out_stall    = 1'b0;
  sample_t                   out_wet_left;
  sample_t                   out_wet_right;
  logic                      cfg_valid    = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;

  logic        hold_ask = 1'b0;
  int unsigned run_cycles = 0;
  int          n_errors = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_settings = 0;
  int          burst_left = 0;
  bit          steady_send = 1'b0;

  // model state
  sample_t                  echo_mem_l [ECHO_DEPTH];
  sample_t                  echo_mem_r [ECHO_DEPTH];
  sample_t                  room_mem_l [ROOM_DEPTH];
  sample_t                  room_mem_r [ROOM_DEPTH];
  int                       echo_wp = 0;
  int                       room_wp = 0;
  logic [ECHO_LEN_BITS-1:0] echo_len_q   = RST_ECHO_LENGTH;
  logic [ROOM_LEN_BITS-1:0] room_len_l_q = RST_ROOM_LENGTH_LEFT;
  logic [ROOM_LEN_BITS-1:0] room_len_r_q = RST_ROOM_LENGTH_RIGHT;
  gain_t                    echo_fb_q    = RST_ECHO_FEEDBACK;
  gain_t                    room_fb_q    = RST_ROOM_FEEDBACK;
  gain_t                    echo_wet_q   = RST_ECHO_WET;
  gain_t                    room_wet_q   = RST_ROOM_WET;

  wet_pair_t pending_wet [$];

  stereo_cross_feedback_delay #(
    .ECHO_DEPTH(ECHO_DEPTH),
    .ROOM_DEPTH(ROOM_DEPTH)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_dry_left  (in_dry_left),
    .in_dry_right (in_dry_right),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_wet_left (out_wet_left),
    .out_wet_right(out_wet_right),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    run_cycles <= run_cycles + 1;
    if (run_cycles == RUN_LIMIT) begin
      $display("stereo_cross_feedback_delay test failed");
      $finish;
    end
  end

  // Q2.30 sum to Q1.15: add half, floor shift, clip
  function automatic sample_t round_clip(input longint acc);
    longint hi;
    longint lo;
    longint r;
    hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lo = -(longint'(1) <<< (SAMPLE_BITS - 1));
    r  = (acc + 16384) >>> 15;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return sample_t'(r);
  endfunction

  function automatic int tap_len(input int len, input int depth);
    if (len < 1) return 1;
    if (len > depth - 1) return depth - 1;
    return len;
  endfunction

  // one stereo pair through both line pairs; taps read before any store is written
  function automatic wet_pair_t mix_step(input sample_t dl, input sample_t dr);
    int        e_rd;
    int        rl_rd;
    int        rr_rd;
    longint    tap_el;
    longint    tap_er;
    longint    tap_rl;
    longint    tap_rr;
    longint    dry_l;
    longint    dry_r;
    wet_pair_t res;
    e_rd   = (echo_wp + ECHO_DEPTH - tap_len(int'(echo_len_q), ECHO_DEPTH)) % ECHO_DEPTH;
    rl_rd  = (room_wp + ROOM_DEPTH - tap_len(int'(room_len_l_q), ROOM_DEPTH)) % ROOM_DEPTH;
    rr_rd  = (room_wp + ROOM_DEPTH - tap_len(int'(room_len_r_q), ROOM_DEPTH)) % ROOM_DEPTH;
    tap_el = longint'(echo_mem_l[e_rd]);
    tap_er = longint'(echo_mem_r[e_rd]);
    tap_rl = longint'(room_mem_l[rl_rd]);
    tap_rr = longint'(room_mem_r[rr_rd]);
    dry_l  = longint'(dl);
    dry_r  = longint'(dr);
    echo_mem_l[echo_wp] = round_clip(dry_l * 32768 + tap_er * longint'(echo_fb_q));
    echo_mem_r[echo_wp] = round_clip(dry_r * 32768 + tap_el * longint'(echo_fb_q));
    room_mem_l[room_wp] = round_clip(dry_l * longint'(DRY_ROOM_GAIN)
                                     + tap_rr * longint'(room_fb_q));
    room_mem_r[room_wp] = round_clip(dry_r * longint'(DRY_ROOM_GAIN)
                                     + tap_rl * longint'(room_fb_q));
    res.wl = round_clip(dry_l * 32768 + tap_el * longint'(echo_wet_q)
                        + tap_rl * longint'(room_wet_q));
    res.wr = round_clip(dry_r * 32768 + tap_er * longint'(echo_wet_q)
                        + tap_rr * longint'(room_wet_q));
    echo_wp = (echo_wp + 1) % ECHO_DEPTH;
    room_wp = (room_wp + 1) % ROOM_DEPTH;
    return res;
  endfunction

  function automatic void mirror_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                     input logic [CFG_DATA_BITS-1:0] d);
    case (idx)
      CFG_ECHO_LENGTH:       echo_len_q   = d[ECHO_LEN_BITS-1:0];
      CFG_ROOM_LENGTH_LEFT:  room_len_l_q = d[ROOM_LEN_BITS-1:0];
      CFG_ROOM_LENGTH_RIGHT: room_len_r_q = d[ROOM_LEN_BITS-1:0];
      CFG_ECHO_FEEDBACK:     echo_fb_q    = d[GAIN_BITS-1:0];
      CFG_ROOM_FEEDBACK:     room_fb_q    = d[GAIN_BITS-1:0];
      CFG_ECHO_WET:          echo_wet_q   = d[GAIN_BITS-1:0];
      CFG_ROOM_WET:          room_wet_q   = d[GAIN_BITS-1:0];
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (n_errors < PRINT_CAP)
      $display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
    n_errors++;
  endtask

  // valid stays high across back-to-back writes; caller lowers it at the end
  task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    mirror_reg(idx, d);
  endtask

  task automatic program_regs(input knob_set_t k);
    cfg_write(CFG_ECHO_LENGTH, k.echo_len);
    cfg_write(CFG_ROOM_LENGTH_LEFT, k.room_len_l);
    cfg_write(CFG_ROOM_LENGTH_RIGHT, k.room_len_r);
    cfg_write(CFG_ECHO_FEEDBACK, k.echo_fb);
    cfg_write(CFG_ROOM_FEEDBACK, k.room_fb);
    cfg_write(CFG_ECHO_WET, k.echo_wet);
    cfg_write(CFG_ROOM_WET, k.room_wet);
    cfg_write(CFG_SPARE_INDEX, CFG_DATA_BITS'($urandom));
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_wet.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_pair(input sample_t l, input sample_t r, input bit typed,
                           input sample_t tl, input sample_t tr);
    wet_pair_t model;
    int        gap;
    if (burst_left == 0) begin
      burst_left = steady_send ? 64 : $urandom_range(1, 24);
      gap        = steady_send ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_dry_left  <= l;
    in_dry_right <= r;
    do @(posedge clk); while (in_stall);
    model = mix_step(l, r);
    if (typed) begin
      model.wl = tl;
      model.wr = tr;
    end
    pending_wet.push_back(model);
    n_sent++;
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          2:       return 16'shFFFF;
          default: return 16'sh0000;
        endcase
      end
      1, 2, 3: return sample_t'(int'($urandom_range(0, 4000)) - 2000);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 15'h7FFF;
      default: return CFG_DATA_BITS'($urandom);
    endcase
  endfunction

  // mostly short taps so echoes come back within a phase
  function automatic int pick_len(input int max_len);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return max_len;
      2:       return $urandom_range(1, 1200);
      default: return $urandom_range(1, 48);
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] room_len_word(input int len);
    // top bit lies past the room length register and must drop out
    return {1'($urandom), ROOM_LEN_BITS'(len)};
  endfunction

  // receiver: random stall modes over random spans, plus one long hold-off
  initial begin
    rx_mode_t mode;
    int       span;
    int       hold_left;
    bit       held;
    mode      = RX_FREE;
    span      = 0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (span == 0) begin
          mode = rx_mode_t'($urandom_range(0, 2));
          span = $urandom_range(20, 300);
        end
        span--;
        case (mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          default:  out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    wet_pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_wet.size() == 0) begin
        flag_mismatch("wet pair with nothing pending", out_wet_left, 0);
      end else begin
        want = pending_wet.pop_front();
        if (out_wet_left !== want.wl)
          flag_mismatch("wet_left", out_wet_left, want.wl);
        if (out_wet_right !== want.wr)
          flag_mismatch("wet_right", out_wet_right, want.wr);
        n_checked++;
      end
    end
  end

  initial begin
    knob_set_t knobs;
    sample_t   l;
    sample_t   r;
    for (int i = 0; i < ECHO_DEPTH; i++) begin
      echo_mem_l[i] = '0;
      echo_mem_r[i] = '0;
    end
    for (int i = 0; i < ROOM_DEPTH; i++) begin
      room_mem_l[i] = '0;
      room_mem_r[i] = '0;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < PROBE_AT_RESET; i++)
      push_pair(probe_rows[i].dl, probe_rows[i].dr, probe_rows[i].typed,
                probe_rows[i].wl, probe_rows[i].wr);
    drain_block();

    // zero lengths act as one; room left gets only the out-of-range bit
    knobs.echo_len   = '0;
    knobs.room_len_l = 15'h4000;
    knobs.room_len_r = 15'h4001;
    knobs.echo_fb    = 15'h7FFF;
    knobs.room_fb    = 15'h7FFF;
    knobs.echo_wet   = 15'h7FFF;
    knobs.room_wet   = 15'h7FFF;
    program_regs(knobs);
    @(posedge clk);
    for (int i = PROBE_AT_RESET; i < PROBE_ROWS; i++)
      push_pair(probe_rows[i].dl, probe_rows[i].dr, probe_rows[i].typed,
                probe_rows[i].wl, probe_rows[i].wr);
    drain_block();

    for (int p = 0; p < RAND_PHASES; p++) begin
      knobs.echo_len   = CFG_DATA_BITS'(pick_len(ECHO_DEPTH - 1));
      knobs.room_len_l = room_len_word(pick_len(ROOM_DEPTH - 1));
      knobs.room_len_r = room_len_word(pick_len(ROOM_DEPTH - 1));
      knobs.echo_fb    = pick_gain();
      knobs.room_fb    = pick_gain();
      knobs.echo_wet   = pick_gain();
      knobs.room_wet   = pick_gain();
      if (p == 0) begin
        knobs.echo_len   = 15'h7FFF;
        knobs.room_len_l = 15'h3FFF;
        knobs.room_len_r = 15'h7FFF;
      end else if (p == 1) begin
        knobs.echo_fb  = '0;
        knobs.room_fb  = '0;
        knobs.echo_wet = '0;
        knobs.room_wet = '0;
      end
      program_regs(knobs);
      @(posedge clk);
      steady_send = (p == 3 || p == 4);
      burst_left  = 0;
      if (p == 4) hold_ask <= 1'b1;
      for (int k = 0; k < PAIRS_PER_PHASE; k++) begin
        l = pick_sample();
        r = ($urandom_range(0, 7) == 0) ? l : pick_sample();
        push_pair(l, r, 1'b0, '0, '0);
      end
      drain_block();
    end

    $display("sent %0d stereo pairs over %0d register settings (incl. clipping, zero and max",
             n_sent, n_settings);
    $display("lengths, long output hold-off); %0d wet pairs checked, %0d mismatches",
             n_checked, n_errors);
    if (n_errors == 0) begin
      $display("stereo_cross_feedback_delay test passed");
    end else begin
      $display("stereo_cross_feedback_delay test failed");
    end
    $finish;
  end

endmodule

### stereo_cross_feedback_delay.f
rtl/core/scfd_pkg.sv
rtl/core/scfd_mac.sv
rtl/core/stereo_cross_feedback_delay.sv
rtl/core/scfd_check.sv
tb/stereo_cross_feedback_delay_tb.sv
